/* sv/prewitt_edge_magnitude_core_assert.svh */
// Assertion macros for the Prewitt edge magnitude core.
// Included by the top level; no other dependencies.
`ifndef PREWITT_EDGE_MAGNITUDE_CORE_ASSERT_SVH
`define PREWITT_EDGE_MAGNITUDE_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PEM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pem assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pem assertion failed");

`endif

/* sv/pem_pkg.sv */
// Shared types and constants of the Prewitt edge magnitude core.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package pem_pkg;

	localparam int LUMA_W     = 8;
	localparam int COL_OUT_W  = 8;
	localparam int ROW_W      = 12;
	localparam int FW_W       = 9;
	localparam int FH_W       = 12;
	localparam int MIN_SIZE   = 3;
	localparam int FW_RESET   = 200;
	localparam int FH_RESET   = 200;
	localparam int ROOT_STEPS = 8;
	localparam int STEP_W     = $clog2(ROOT_STEPS);
	localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS - 1);
	localparam logic [LUMA_W-1:0] MAG_MAX   = 8'd255;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic accept;
		logic load_win;
		logic grad;
		logic square;
		logic sum;
		logic root_step;
		logic out_load;
	} pem_cmd_t;

	typedef struct packed {
		logic emit;
		logic out_free;
	} pem_sts_t;

endpackage

`default_nettype wire

/* sv/pem_ctrl.sv */
// Sequencing state machine of the Prewitt edge magnitude core.
// Depends on pem_pkg for the command and status structs.
`default_nettype none

module pem_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  pem_pkg::pem_sts_t  sts,
	output pem_pkg::pem_cmd_t  cmd
);
	import pem_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_WIN    = 3'd1;
	localparam logic [2:0] ST_GRAD   = 3'd2;
	localparam logic [2:0] ST_SQUARE = 3'd3;
	localparam logic [2:0] ST_SUM    = 3'd4;
	localparam logic [2:0] ST_ROOT   = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic [STEP_W-1:0] step_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_WIN;
				end
			end
			ST_WIN: begin
				cmd.load_win = 1'b1;
				state_d      = sts.emit ? ST_GRAD : ST_IDLE;
			end
			ST_GRAD: begin
				cmd.grad = 1'b1;
				state_d  = ST_SQUARE;
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (step_q == ROOT_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.sum) begin
				step_q <= '0;
			end else if (cmd.root_step) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/pem_dp.sv */
// Datapath of the Prewitt edge magnitude core: line stores, window, position,
// gradients, squares, bit-pair square root and output register. Uses pem_pkg.
`default_nettype none

module pem_dp #(
	parameter int MAX_WIDTH = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pem_pkg::pem_cmd_t            cmd,
	output pem_pkg::pem_sts_t            sts,
	input  logic [pem_pkg::LUMA_W-1:0]   luma,
	input  logic                         start_of_frame,
	input  logic [pem_pkg::FW_W-1:0]     frame_width,
	input  logic [pem_pkg::FH_W-1:0]     frame_height,
	input  logic                         m_tready,
	output logic                         m_tvalid,
	output logic [pem_pkg::LUMA_W-1:0]   magnitude,
	output logic [pem_pkg::COL_OUT_W-1:0] center_col,
	output logic [pem_pkg::ROW_W-1:0]    center_row,
	output logic                         last_of_frame
);
	import pem_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = ((AW > FW_W) ? AW : FW_W) + 1;

	logic [LUMA_W-1:0] upper_mem  [MAX_WIDTH];
	logic [LUMA_W-1:0] middle_mem [MAX_WIDTH];

	logic [AW-1:0]     col_q;
	logic [ROW_W-1:0]  row_q;
	logic [AW-1:0]     cur_c_q;
	logic [ROW_W-1:0]  cur_r_q;
	logic [LUMA_W-1:0] px_q;
	logic [LUMA_W-1:0] upper_rd_q;
	logic [LUMA_W-1:0] middle_rd_q;
	logic [LUMA_W-1:0] win_q [3][3];

	logic [COL_OUT_W-1:0] ctr_col_q;
	logic [ROW_W-1:0]     ctr_row_q;
	logic                 last_q;

	logic signed [10:0] gx_q;
	logic signed [10:0] gy_q;
	logic [19:0]        gx2_q;
	logic [19:0]        gy2_q;
	logic [15:0]        rad_q;
	logic [9:0]         rem_q;
	logic [7:0]         root_q;
	logic               sat_q;
	logic               out_valid_q;

	logic [AW-1:0]      rd_addr;
	logic [ROW_W-1:0]   start_r;
	logic [CW-1:0]      fw_ext;
	logic [CW-1:0]      eff_w;
	logic [FH_W-1:0]    eff_h;
	logic [CW-1:0]      cur_c_ext;
	logic [CW-1:0]      next_c;
	logic [ROW_W:0]     next_r;
	logic [CW-1:0]      ctr_col_ext;
	logic [9:0]         top_sum;
	logic [9:0]         bot_sum;
	logic [9:0]         left_sum;
	logic [9:0]         right_sum;
	logic signed [10:0] gx_d;
	logic signed [10:0] gy_d;
	logic signed [21:0] gx_sq;
	logic signed [21:0] gy_sq;
	logic [20:0]        sum_sq;
	logic [11:0]        rem_sh;
	logic [11:0]        trial;
	logic [11:0]        rem_sub;

	assign rd_addr = start_of_frame ? '0 : col_q;
	assign start_r = start_of_frame ? '0 : row_q;

	assign fw_ext = CW'(frame_width);
	always_comb begin
		priority if (fw_ext < CW'(MIN_SIZE)) begin
			eff_w = CW'(MIN_SIZE);
		end else if (fw_ext > CW'(MAX_WIDTH)) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = fw_ext;
		end
	end
	assign eff_h = (frame_height < FH_W'(MIN_SIZE)) ? FH_W'(MIN_SIZE) : frame_height;

	assign cur_c_ext   = CW'(cur_c_q);
	assign next_c      = cur_c_ext + 1'b1;
	assign next_r      = {1'b0, cur_r_q} + 1'b1;
	assign ctr_col_ext = cur_c_ext - 1'b1;

	assign sts.emit = (cur_c_ext >= CW'(2)) && (cur_r_q >= ROW_W'(2))
		&& (cur_c_ext < eff_w) && (cur_r_q < eff_h);
	assign sts.out_free = !out_valid_q || m_tready;

	assign top_sum   = 10'(win_q[0][0]) + 10'(win_q[0][1]) + 10'(win_q[0][2]);
	assign bot_sum   = 10'(win_q[2][0]) + 10'(win_q[2][1]) + 10'(win_q[2][2]);
	assign left_sum  = 10'(win_q[0][0]) + 10'(win_q[1][0]) + 10'(win_q[2][0]);
	assign right_sum = 10'(win_q[0][2]) + 10'(win_q[1][2]) + 10'(win_q[2][2]);
	assign gx_d = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
	assign gy_d = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});

	assign gx_sq  = gx_q * gx_q;
	assign gy_sq  = gy_q * gy_q;
	assign sum_sq = {1'b0, gx2_q} + {1'b0, gy2_q};

	assign rem_sh  = {rem_q, rad_q[15:14]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign rem_sub = rem_sh - trial;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			upper_rd_q <= upper_mem[rd_addr];
		end
		if (cmd.load_win) begin
			upper_mem[cur_c_q] <= middle_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			middle_rd_q <= middle_mem[rd_addr];
		end
		if (cmd.load_win) begin
			middle_mem[cur_c_q] <= px_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else begin
			if (cmd.load_win) begin
				for (int i = 0; i < 3; i++) begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= win_q[i][2];
				end
				win_q[0][2] <= upper_rd_q;
				win_q[1][2] <= middle_rd_q;
				win_q[2][2] <= px_q;
				if (next_c >= eff_w) begin
					col_q <= '0;
					row_q <= (next_r >= {1'b0, eff_h}) ? '0 : next_r[ROW_W-1:0];
				end else begin
					col_q <= next_c[AW-1:0];
					row_q <= cur_r_q;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q    <= luma;
			cur_c_q <= rd_addr;
			cur_r_q <= start_r;
		end
		if (cmd.load_win) begin
			ctr_col_q <= ctr_col_ext[COL_OUT_W-1:0];
			ctr_row_q <= cur_r_q - 1'b1;
			last_q    <= (cur_c_ext == eff_w - 1'b1) && (cur_r_q == eff_h - 1'b1);
		end
		if (cmd.grad) begin
			gx_q <= gx_d;
			gy_q <= gy_d;
		end
		if (cmd.square) begin
			gx2_q <= gx_sq[19:0];
			gy2_q <= gy_sq[19:0];
		end
		if (cmd.sum) begin
			sat_q  <= (sum_sq[20:16] != '0);
			rad_q  <= sum_sq[15:0];
			rem_q  <= '0;
			root_q <= '0;
		end
		if (cmd.root_step) begin
			rad_q <= {rad_q[13:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sub[9:0];
				root_q <= {root_q[6:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[9:0];
				root_q <= {root_q[6:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			magnitude     <= sat_q ? MAG_MAX : root_q;
			center_col    <= ctr_col_q;
			center_row    <= ctr_row_q;
			last_of_frame <= last_q;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

/* sv/prewitt_edge_magnitude_core.sv */
// Prewitt 3x3 edge magnitude core, top level. Uses pem_pkg, pem_ctrl, pem_dp
// and the macros in prewitt_edge_magnitude_core_assert.svh.
// Luma pixels enter in raster order on the s_ stream, one per transaction,
// with s_tuser set on the first pixel of a frame. For every interior pixel
// the m_ stream carries floor(sqrt(gx^2 + gy^2)) saturated at 255 with the
// center column and row; m_tlast marks the last interior result of a frame.
// Border pixels produce no transaction.
// A pixel that yields a result goes through the window load (line stores are
// read on acceptance and written there), gradients, squares, sum and the
// 8-step bit-pair square root; its result shows on m_tvalid in the cycle the
// next pixel can be accepted. A border pixel goes idle after the window load.
// Frame size is written over the APB port at 0x0 (width) and 0x4 (height)
// by the user only while the core is idle; the core does not enforce it. Reset
// sets both to 200 and the position to row 0, column 0; line stores are not
// cleared. With m_tready low a finished result waits in the output register;
// pixels are taken until a second result is ready; it waits until the first is taken.
`default_nettype none

`include "prewitt_edge_magnitude_core_assert.svh"

module prewitt_edge_magnitude_core #(
	parameter int MAX_WIDTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] luma
	input  logic        s_tuser,   // [0] start_of_frame
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] magnitude, [15:8] center_col, [27:16] center_row
	output logic        m_tlast
);
	import pem_pkg::*;

	logic [FW_W-1:0]      frame_width_q;
	logic [FH_W-1:0]      frame_height_q;
	logic                 reg_idx;
	pem_cmd_t             cmd;
	pem_sts_t             sts;
	logic [LUMA_W-1:0]    magnitude;
	logic [COL_OUT_W-1:0] center_col;
	logic [ROW_W-1:0]     center_row;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_W'(FW_RESET);
			frame_height_q <= FH_W'(FH_RESET);
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_W-1:0];
				default:          frame_width_q  <= frame_width_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	pem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pem_dp #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.luma           (s_tdata),
		.start_of_frame (s_tuser),
		.frame_width    (frame_width_q),
		.frame_height   (frame_height_q),
		.m_tready       (m_tready),
		.m_tvalid       (m_tvalid),
		.magnitude      (magnitude),
		.center_col     (center_col),
		.center_row     (center_row),
		.last_of_frame  (m_tlast)
	);

	assign m_tdata = {4'b0000, center_row, center_col, magnitude};

	`PEM_ASSERT_NEXT(a_accept_loads_window, clk, arst_n, cmd.accept, cmd.load_win)
	`PEM_ASSERT_NEXT(a_single_item, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`PEM_ASSERT_IMPL(a_load_needs_room, clk, arst_n, cmd.out_load, sts.out_free)
	`PEM_ASSERT_IMPL(a_interior_row, clk, arst_n, m_tvalid, m_tdata[27:16] != 12'd0)

endmodule

`default_nettype wire

/* sim/tb_prewitt_edge_magnitude_core.sv */
// Self-checking testbench for prewitt_edge_magnitude_core: streams luma frames of several
// sizes, predicts each edge magnitude with its own Prewitt window and compares every result.
// Depends on pem_pkg and the core's RTL only.
module tb_prewitt_edge_magnitude_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_DEPTH   = 256;
	localparam int CLK_PERIOD   = 4;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE       = 32;
	localparam int MAX_PRINTED  = 50;
	localparam int LONG_HOLD    = 300;
	localparam int HOLD_TRIGGER = 16;

	typedef struct packed {
		logic [7:0]  magnitude;
		logic [7:0]  center_col;
		logic [11:0] center_row;
		logic        last_of_frame;
	} edge_result_t;

	typedef enum int {SINK_READY, SINK_MOSTLY, SINK_SPARSE} sink_mode_t;
	typedef enum int {LUMA_RANDOM, LUMA_EXTREME, LUMA_SMOOTH} luma_style_t;

	class edge_scoreboard;
		logic [pem_pkg::FW_W-1:0] width_reg;
		logic [pem_pkg::FH_W-1:0] height_reg;
		logic [7:0] upper_row[LINE_DEPTH];
		logic [7:0] middle_row[LINE_DEPTH];
		logic [7:0] win[3][3];
		int unsigned col_pos;
		int unsigned row_pos;
		edge_result_t pending[$];
		int unsigned errors;
		int unsigned results_checked;
		int unsigned pixels_noted;

		function new();
			width_reg = pem_pkg::FW_W'(pem_pkg::FW_RESET);
			height_reg = pem_pkg::FH_W'(pem_pkg::FH_RESET);
			foreach (upper_row[i]) begin
				upper_row[i] = '0;
				middle_row[i] = '0;
			end
			foreach (win[i, j]) win[i][j] = '0;
			col_pos = 0;
			row_pos = 0;
			errors = 0;
			results_checked = 0;
			pixels_noted = 0;
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
		endfunction

		function void write_size(logic idx, logic [31:0] value);
			if (idx == pem_pkg::REG_FRAME_WIDTH)
				width_reg = value[pem_pkg::FW_W-1:0];
			else
				height_reg = value[pem_pkg::FH_W-1:0];
		endfunction

		function logic [7:0] clipped_root(int unsigned energy);
			int unsigned root;
			root = 0;
			while (root < 255 && (root + 1) * (root + 1) <= energy)
				root++;
			return root[7:0];
		endfunction

		function void note_pixel(logic [7:0] luma, logic sof);
			int unsigned eff_w;
			int unsigned eff_h;
			int unsigned slot;
			int gx;
			int gy;
			edge_result_t res;
			eff_w = width_reg;
			if (eff_w < pem_pkg::MIN_SIZE) eff_w = pem_pkg::MIN_SIZE;
			if (eff_w > LINE_DEPTH) eff_w = LINE_DEPTH;
			eff_h = height_reg;
			if (eff_h < pem_pkg::MIN_SIZE) eff_h = pem_pkg::MIN_SIZE;
			pixels_noted++;
			if (sof) begin
				col_pos = 0;
				row_pos = 0;
			end
			slot = col_pos % LINE_DEPTH;
			for (int i = 0; i < 3; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2] = upper_row[slot];
			win[1][2] = middle_row[slot];
			win[2][2] = luma;
			upper_row[slot] = middle_row[slot];
			middle_row[slot] = luma;
			if (col_pos >= 2 && row_pos >= 2 && col_pos < eff_w && row_pos < eff_h) begin
				gx = 0;
				gy = 0;
				for (int j = 0; j < 3; j++) begin
					gx = gx + int'(win[2][j]) - int'(win[0][j]);
					gy = gy + int'(win[j][0]) - int'(win[j][2]);
				end
				res.magnitude = clipped_root(gx * gx + gy * gy);
				res.center_col = 8'(col_pos - 1);
				res.center_row = 12'(row_pos - 1);
				res.last_of_frame = (col_pos == eff_w - 1) && (row_pos == eff_h - 1);
				pending.push_back(res);
			end
			col_pos++;
			if (col_pos >= eff_w) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= eff_h) row_pos = 0;
			end
		endfunction

		function void check_result(logic [31:0] data, logic tlast);
			edge_result_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result data=%h last=%b", data, tlast));
				return;
			end
			want = pending.pop_front();
			results_checked++;
			if (data[7:0] !== want.magnitude)
				report($sformatf("magnitude %0d, expected %0d at (%0d,%0d)", data[7:0],
					want.magnitude, want.center_col, want.center_row));
			if (data[15:8] !== want.center_col)
				report($sformatf("center_col %0d, expected %0d", data[15:8],
					want.center_col));
			if (data[27:16] !== want.center_row)
				report($sformatf("center_row %0d, expected %0d", data[27:16],
					want.center_row));
			if (data[31:28] !== 4'd0)
				report($sformatf("padding bits %h not zero", data[31:28]));
			if (tlast !== want.last_of_frame)
				report($sformatf("last_of_frame %b, expected %b at (%0d,%0d)", tlast,
					want.last_of_frame, want.center_col, want.center_row));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] luma
	logic        s_tuser;   // [0] start_of_frame
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [7:0] magnitude, [15:8] center_col, [27:16] center_row
	logic        m_tlast;

	edge_scoreboard sb = new();
	int unsigned cycle_count = 0;
	int unsigned sizes_run = 0;

	prewitt_edge_magnitude_core #(.MAX_WIDTH(LINE_DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// A result can never stem from the pixel taken at the same edge, so it is checked first.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tlast);
			if (s_tvalid && s_tready)
				sb.note_pixel(s_tdata, s_tuser);
		end
	end

	initial begin : result_sink
		int unsigned hold_left;
		int unsigned mode_left;
		logic held;
		sink_mode_t mode;
		m_tready = 1'b0;
		hold_left = 0;
		mode_left = 0;
		held = 1'b0;
		mode = SINK_READY;
		forever begin
			@(negedge clk);
			if (!held && sb.results_checked >= HOLD_TRIGGER) begin
				held = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = sink_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (mode)
					SINK_READY: begin
						m_tready <= 1'b1;
					end
					SINK_MOSTLY: begin
						m_tready <= ($urandom_range(0, 3) != 0);
					end
					default: begin
						m_tready <= ($urandom_range(0, 3) == 0);
					end
				endcase
			end
		end
	end

	task automatic reg_write(input logic idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_size(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic reg_check(input logic idx, input logic [31:0] want);
		logic [31:0] value;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (value !== want)
			sb.report($sformatf("register %0d reads %h, expected %h", idx, value, want));
	endtask

	task automatic set_frame_size(input logic [31:0] w_val, input logic [31:0] h_val);
		reg_write(pem_pkg::REG_FRAME_WIDTH, w_val);
		reg_write(pem_pkg::REG_FRAME_HEIGHT, h_val);
		reg_check(pem_pkg::REG_FRAME_WIDTH, {23'd0, w_val[8:0]});
		reg_check(pem_pkg::REG_FRAME_HEIGHT, {20'd0, h_val[11:0]});
		sizes_run++;
	endtask

	task automatic send_pixel(input logic [7:0] luma, input logic sof);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= luma;
		s_tuser <= sof;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic pause_input(input int unsigned cycles);
		repeat (cycles) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tuser <= 1'b0;
		end
	endtask

	task automatic wait_results_drained();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Mostly whole frames with random content; some frames rely on the position wrap,
	// and now and then a start of frame cuts the current one short.
	task automatic run_frames(input logic [31:0] w_val, input logic [31:0] h_val,
			input int unsigned n_items);
		int unsigned eff_w;
		int unsigned eff_h;
		int unsigned idx;
		int unsigned burst_left;
		int prev;
		int step;
		logic sof;
		luma_style_t style;
		set_frame_size(w_val, h_val);
		eff_w = w_val[8:0];
		if (eff_w < pem_pkg::MIN_SIZE) eff_w = pem_pkg::MIN_SIZE;
		if (eff_w > LINE_DEPTH) eff_w = LINE_DEPTH;
		eff_h = h_val[11:0];
		if (eff_h < pem_pkg::MIN_SIZE) eff_h = pem_pkg::MIN_SIZE;
		idx = 0;
		prev = 128;
		burst_left = 0;
		for (int unsigned n = 0; n < n_items; n++) begin
			if (burst_left == 0) begin
				if ($urandom_range(0, 3) != 0)
					pause_input($urandom_range(1, 8));
				burst_left = $urandom_range(1, 64);
			end
			burst_left--;
			if (n == 0)
				sof = 1'b1;
			else if (idx == 0)
				sof = ($urandom_range(0, 2) != 0);
			else
				sof = ($urandom_range(0, 299) == 0);
			style = luma_style_t'($urandom_range(0, 3) > 2 ? 2 : $urandom_range(0, 2));
			case (style)
				LUMA_RANDOM: begin
					prev = $urandom_range(0, 255);
				end
				LUMA_EXTREME: begin
					prev = ($urandom_range(0, 1) != 0) ? 255 : 0;
				end
				default: begin
					step = $urandom_range(0, 16);
					prev = prev + step - 8;
					if (prev < 0) prev = 0;
					if (prev > 255) prev = 255;
				end
			endcase
			send_pixel(8'(prev), sof);
			if (sof) idx = 0;
			idx++;
			if (idx == eff_w * eff_h) idx = 0;
		end
		pause_input(1);
		wait_results_drained();
	endtask

	initial begin : stimulus
		logic [7:0] luma;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		reg_check(pem_pkg::REG_FRAME_WIDTH, pem_pkg::FW_RESET);
		reg_check(pem_pkg::REG_FRAME_HEIGHT, pem_pkg::FH_RESET);

		// Both sizes below the minimum clamp to 3x3. Frame one saturates on the row
		// gradient, frame two arrives without a start flag and holds a ramp, frame
		// three is flat white.
		set_frame_size(32'd0, 32'd1);
		for (int f = 0; f < 3; f++) begin
			for (int i = 0; i < 9; i++) begin
				case (f)
					0: luma = (i / 3 == 2) ? 8'd255 : 8'd0;
					1: luma = 8'((i % 3) * 20 + i / 3);
					default: luma = 8'd255;
				endcase
				send_pixel(luma, (i == 0) && (f != 1));
			end
		end
		pause_input(1);
		wait_results_drained();

		run_frames(32'd5, 32'd4, 40);
		run_frames(32'd2, 32'd4095, 30);
		run_frames(32'd16, 32'd0, 48);
		run_frames(32'hFFFF_FFFF, 32'h0000_F003, 530);
		run_frames(32'd11, 32'd7, 40);
		run_frames(32'd3, 32'd3, 18);

		$display("Streamed %0d pixels over %0d frame sizes, from clamped 3x3 up to 256 wide;",
			sb.pixels_noted, sizes_run);
		$display("checked %0d edge results across output stalls and frame restarts.",
			sb.results_checked);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
